/* src/bwcr_pkg.sv */
// Package: types, constants and small helpers for the waveform column renderer.
`default_nettype none
package bwcr_pkg;
  localparam int MAX_POINTS = 65536;
  localparam int BAND_BITS  = 12;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int POINT_W    = 4 * BAND_BITS;
  localparam logic [11:0] MIN_COLUMNS = 12'd100;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_RENDER = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] REG_EXPECTED = 2'd0;
  localparam logic [1:0] REG_COLUMNS  = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_RECT     = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] band_low;
    logic [11:0] band_lowmid;
    logic [11:0] band_mid;
    logic [11:0] band_high;
    logic [11:0] column_index;
  } in_item_t;

  typedef struct packed {
    logic        column_drawn;
    logic [15:0] low_top;
    logic [15:0] low_bottom;
    logic [15:0] lowmid_top;
    logic [15:0] lowmid_bottom;
    logic [15:0] mid_top;
    logic [15:0] mid_bottom;
    logic [15:0] high_top;
    logic [15:0] high_bottom;
  } out_item_t;

  typedef struct packed {
    logic [16:0] expected_points;
    logic [11:0] column_count;
    logic [11:0] view_height;
    logic        rectified_mode;
  } cfg_t;

  // Divider handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic        start;
    logic [40:0] dividend;
    logic [20:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [40:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

/* src/bwcr_ram.sv */
// Generic single-port-write, registered-read synchronous RAM.
`default_nettype none
module bwcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/bwcr_div.sv */
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module bwcr_div (
  input  wire                clk,
  input  wire                rst,
  input  bwcr_pkg::div_req_t req,
  output bwcr_pkg::div_rsp_t rsp
);
  import bwcr_pkg::*;
  logic [40:0] quo;
  logic [20:0] rem;
  logic [5:0]  cnt;
  logic        busy;
  logic        done;
  logic [21:0] trial;

  assign trial = {rem, quo[40]} - {1'b0, req.divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo <= req.dividend;
        rem <= '0;
        cnt <= 6'd0;
      end else if (busy) begin
        if (!trial[21]) begin
          rem <= trial[20:0];
          quo <= {quo[39:0], 1'b1};
        end else begin
          rem <= {rem[19:0], quo[40]};
          quo <= {quo[39:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd40) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign rsp = {done, quo};
endmodule
`default_nettype wire

/* src/band_waveform_column_renderer_unit.sv */
// Top level: point store, render sequencer, shared divider and output register.
//
//  channel | direction | handshake      | payload
//  in      | input     | in_valid/stall | in_item_t
//  out     | output    | out_valid/stall| out_item_t
//  cfg     | input     | valid/ready    | index, data
//
// Append and clear complete in the idle state. A render takes the divisions for the
// drawn column count and the bin bounds through the shared divider, reads each
// point of the bin from the store, then multiplies, sums, outputs and hands off,
// and adds three scaling divisions when the stack overflows. Reset is synchronous
// and clears the count and control; the store needs no clearing. While a result
// waits behind out_stall the next transaction is not taken until the output
// register is free.
`default_nettype none
module band_waveform_column_renderer_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  bwcr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output bwcr_pkg::out_item_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_index,
  input  wire [16:0]          cfg_data
);
  import bwcr_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DRAWN = 10'b0000000010,
    S_START = 10'b0000000100,
    S_END   = 10'b0000001000,
    S_READ  = 10'b0000010000,
    S_HGT   = 10'b0000100000,
    S_SUM   = 10'b0001000000,
    S_SCL   = 10'b0010000000,
    S_OUT   = 10'b0100000000,
    S_WAIT  = 10'b1000000000
  } state_t;

  state_t      state;
  cfg_t        cfg;
  logic [CNT_W-1:0] stored_count;
  logic [11:0] col;
  logic [16:0] total;
  logic [11:0] cols;
  logic [16:0] start_pt, end_pt;
  logic [CNT_W-1:0] rd_ptr;
  logic        rd_pend, rd_last;
  logic [BAND_BITS-1:0] bm [4];
  logic [16:0] bar;
  logic [16:0] h [4];
  logic [18:0] s [4];
  logic [1:0]  scl_idx;
  logic        div_busy;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [POINT_W-1:0] rdata;
  logic        in_acc;
  logic        we;
  logic [ADDR_W-1:0] raddr;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_acc    = in_valid && !in_stall;
  assign we = in_acc && in_data.operation == OP_APPEND && stored_count < CNT_W'(MAX_POINTS);

  bwcr_ram #(.WIDTH(POINT_W), .DEPTH(MAX_POINTS)) u_store (
    .clk(clk), .we(we), .waddr(stored_count[ADDR_W-1:0]),
    .wdata({in_data.band_low[BAND_BITS-1:0], in_data.band_lowmid[BAND_BITS-1:0],
            in_data.band_mid[BAND_BITS-1:0], in_data.band_high[BAND_BITS-1:0]}),
    .raddr(raddr), .rdata(rdata)
  );
  assign raddr = rd_ptr[ADDR_W-1:0];

  bwcr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.expected_points <= '0;
      cfg.column_count <= 12'd100;
      cfg.view_height <= 12'd256;
      cfg.rectified_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_EXPECTED: cfg.expected_points <= cfg_data;
        REG_COLUMNS:  cfg.column_count <= cfg_data[11:0];
        REG_HEIGHT:   cfg.view_height <= cfg_data[11:0];
        REG_RECT:     cfg.rectified_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // The stack level under the current scaling step.
  logic [18:0] s_cur;
  always_comb begin
    case (scl_idx)
      2'd0: s_cur = s[3];
      2'd1: s_cur = s[2];
      default: s_cur = s[1];
    endcase
  end

  logic [16:0] base;
  assign base = bar;

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      stored_count <= '0;
      out_valid <= 1'b0;
      div_busy <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.operation)
              OP_APPEND: if (we) stored_count <= stored_count + CNT_W'(1);
              OP_CLEAR: stored_count <= '0;
              OP_RENDER: begin
                col <= in_data.column_index;
                total <= (cfg.expected_points > 17'(stored_count)) ?
                         cfg.expected_points : 17'(stored_count);
                cols <= (cfg.column_count < MIN_COLUMNS) ? MIN_COLUMNS : cfg.column_count;
                bar <= cfg.rectified_mode ? {1'b0, cfg.view_height, 4'b0}
                                          : {2'b0, cfg.view_height, 3'b0};
                for (int b = 0; b < 4; b++) bm[b] <= '0;
                if (stored_count == '0) begin
                  out_data <= '0;
                  state <= S_WAIT;
                end else state <= S_DRAWN;
              end
              default: ;
            endcase
          end
        end
        S_DRAWN: begin
          if (!div_busy) begin
            dreq.start <= 1'b1;
            dreq.dividend <= 41'(cols) * 41'(stored_count);
            dreq.divisor <= 21'(total);
            div_busy <= 1'b1;
          end else if (drsp.done) begin
            div_busy <= 1'b0;
            if (41'(col) >= ((drsp.quotient == '0) ? 41'd1 : drsp.quotient)) begin
              out_data <= '0;
              state <= S_WAIT;
            end else state <= S_START;
          end
        end
        S_START: begin
          if (!div_busy) begin
            dreq.start <= 1'b1;
            dreq.dividend <= 41'(col) * 41'(total);
            dreq.divisor <= 21'(cols);
            div_busy <= 1'b1;
          end else if (drsp.done) begin
            div_busy <= 1'b0;
            start_pt <= drsp.quotient[16:0];
            state <= S_END;
          end
        end
        S_END: begin
          if (!div_busy) begin
            dreq.start <= 1'b1;
            dreq.dividend <= 41'(13'(col) + 13'd1) * 41'(total);
            dreq.divisor <= 21'(cols);
            div_busy <= 1'b1;
          end else if (drsp.done) begin
            div_busy <= 1'b0;
            if (18'(start_pt) >= 18'(stored_count)) state <= S_HGT;
            else begin
              if (drsp.quotient[17:0] > 18'(stored_count)) end_pt <= 17'(stored_count);
              else if (drsp.quotient[16:0] == start_pt) end_pt <= start_pt + 17'd1;
              else end_pt <= drsp.quotient[16:0];
              rd_ptr <= CNT_W'(start_pt);
              rd_last <= 1'b0;
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // One address issued per cycle; data returns in the cycle after.
          rd_pend <= !rd_last;
          if (!rd_last) begin
            if (17'(rd_ptr) + 17'd1 >= end_pt) rd_last <= 1'b1;
            else rd_ptr <= rd_ptr + CNT_W'(1);
          end
          if (rd_pend) begin
            for (int b = 0; b < 4; b++)
              if (rdata[(3-b)*BAND_BITS +: BAND_BITS] > bm[b])
                bm[b] <= rdata[(3-b)*BAND_BITS +: BAND_BITS];
          end
          if (rd_last && !rd_pend) state <= S_HGT;
        end
        S_HGT: begin
          for (int b = 0; b < 4; b++)
            h[b] <= 17'((29'(bm[b]) * 29'(bar)) >> BAND_BITS);
          state <= S_SUM;
        end
        S_SUM: begin
          s[3] <= 19'(h[3]);
          s[2] <= 19'(h[3]) + 19'(h[2]);
          s[1] <= 19'(h[3]) + 19'(h[2]) + 19'(h[1]);
          s[0] <= 19'(h[3]) + 19'(h[2]) + 19'(h[1]) + 19'(h[0]);
          scl_idx <= 2'd0;
          state <= S_SCL;
        end
        S_SCL: begin
          if (s[0] <= 19'(bar)) state <= S_OUT;
          else if (!div_busy) begin
            dreq.start <= 1'b1;
            dreq.dividend <= 41'(s_cur) * 41'(bar);
            dreq.divisor <= 21'(s[0]);
            div_busy <= 1'b1;
          end else if (drsp.done) begin
            div_busy <= 1'b0;
            case (scl_idx)
              2'd0: s[3] <= drsp.quotient[18:0];
              2'd1: s[2] <= drsp.quotient[18:0];
              default: s[1] <= drsp.quotient[18:0];
            endcase
            if (scl_idx == 2'd2) begin
              s[0] <= 19'(bar);
              state <= S_OUT;
            end
            scl_idx <= scl_idx + 2'd1;
          end
        end
        S_OUT: begin
          out_data.column_drawn <= 1'b1;
          out_data.low_top <= 16'(base - s[0][16:0]);
          out_data.lowmid_top <= 16'(base - s[1][16:0]);
          out_data.mid_top <= 16'(base - s[2][16:0]);
          out_data.high_top <= 16'(base - s[3][16:0]);
          out_data.low_bottom <= cfg.rectified_mode ? base[15:0] : 16'(base + s[0][16:0]);
          out_data.lowmid_bottom <= cfg.rectified_mode ? base[15:0] : 16'(base + s[1][16:0]);
          out_data.mid_bottom <= cfg.rectified_mode ? base[15:0] : 16'(base + s[2][16:0]);
          out_data.high_bottom <= cfg.rectified_mode ? base[15:0] : 16'(base + s[3][16:0]);
          state <= S_WAIT;
        end
        S_WAIT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The fill count never passes the store depth.
  assert property (@(posedge clk) disable iff (rst) stored_count <= CNT_W'(MAX_POINTS))
    else $error("stored_count beyond store depth");
  // A result only appears after the sequencer's hand-off state.
  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state == S_WAIT))
    else $error("result raised outside hand-off");
  // Nothing is taken while the sequencer is busy.
  assert property (@(posedge clk) disable iff (rst) (state != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
endmodule
`default_nettype wire
